### rtl/core/amgt_pkg.sv
package amgt_pkg;

    // Fixed field widths
    localparam int VX_W    = 4;
    localparam int ROW_W   = 16;
    localparam int CNT_W   = 5;
    localparam int VX_MAX  = 16;
    localparam int MAX_VERTICES_DEF = 16;

    // Search lanes over the current row
    localparam int LANE_W  = 4;
    localparam int LANES   = ROW_W / LANE_W;
    localparam int OFF_W   = $clog2(LANE_W);

    // Input opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_START = 1'b1;

    // Register indexes
    localparam logic [1:0] REG_WALK_MODE    = 2'd0;
    localparam logic [1:0] REG_START_VERTEX = 2'd1;
    localparam logic [1:0] REG_VERTEX_COUNT = 2'd2;

    // Walk modes
    localparam logic MODE_BFS = 1'b0;
    localparam logic MODE_DFS = 1'b1;

    typedef logic [VX_W-1:0]  t_vertex;
    typedef logic [ROW_W-1:0] t_row;

    typedef struct packed {
        logic             found;
        logic [OFF_W-1:0] offset;
    } t_lane_res;

    typedef struct packed {
        logic    found;
        t_vertex vertex;
    } t_pick;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BFS_DEQ,
        ST_BFS_EXP,
        ST_DFS,
        ST_FINISH
    } t_state;

endpackage

### rtl/core/amgt_if.sv
interface amgt_in_if;
    import amgt_pkg::*;
    logic              valid;
    logic              ready;
    logic              opcode;
    logic [VX_W-1:0]   row_index;
    logic [ROW_W-1:0]  row_bits;

    modport source (output valid, output opcode, output row_index, output row_bits,
                    input ready);
    modport sink   (input valid, input opcode, input row_index, input row_bits,
                    output ready);
endinterface

interface amgt_out_if;
    import amgt_pkg::*;
    logic             valid;
    logic             ready;
    logic [VX_W-1:0]  visited_vertex;
    logic             last_vertex;

    modport source (output valid, output visited_vertex, output last_vertex,
                    input ready);
    modport sink   (input valid, input visited_vertex, input last_vertex,
                    output ready);
endinterface

### rtl/core/amgt_lane.sv
module amgt_lane
    import amgt_pkg::*;
#(
    parameter int BASE = 0
) (
    input  logic [LANE_W-1:0] i_row,
    input  logic [LANE_W-1:0] i_visited,
    input  logic [CNT_W-1:0]  i_count,
    output t_lane_res         o_res
);

    // Find the lowest unvisited, in-range neighbour in this slice
    always_comb begin
        o_res = '0;
        for (int k = LANE_W - 1; k >= 0; k--) begin
            if (i_row[k] && !i_visited[k] && (CNT_W'(BASE + k) < i_count)) begin
                o_res.found  = 1'b1;
                o_res.offset = OFF_W'(k);
            end
        end
    end

endmodule

### rtl/core/amgt_merge.sv
module amgt_merge
    import amgt_pkg::*;
(
    input  t_lane_res [LANES-1:0] i_lanes,
    output t_pick                 o_pick
);

    // Take the lowest lane that found a candidate
    always_comb begin
        o_pick = '0;
        for (int g = LANES - 1; g >= 0; g--) begin
            if (i_lanes[g].found) begin
                o_pick.found  = 1'b1;
                o_pick.vertex = VX_W'(g * LANE_W + int'(i_lanes[g].offset));
            end
        end
    end

endmodule

### rtl/core/adjacency_matrix_graph_traversal_top.sv
// Row load: taken whenever the block is idle, no result.
// Breadth-first start: per vertex a dequeue, an enqueue step per neighbour queued and a final
// empty search, then the finish.
// Depth-first start: a push per vertex reached and a pop per vertex, then the finish.
// A new item is taken only once the walk is done; result-side stalls add cycles.
// Synchronous active-low reset clears the matrix, the pointers, the configuration registers and the state.
module adjacency_matrix_graph_traversal_top
    import amgt_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    amgt_in_if.sink      i_in_ch,
    amgt_out_if.source   o_out_ch,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int LIM = (MAX_VERTICES < VX_MAX) ? MAX_VERTICES : VX_MAX;
    localparam int IW  = $clog2(LIM);
    localparam int PW  = $clog2(LIM + 1);
    localparam logic [CNT_W-1:0] LIM_C    = CNT_W'(LIM);
    localparam logic [PW-1:0]    ONE_P    = PW'(1);
    localparam logic [PW-1:0]    TWO_P    = PW'(2);
    localparam t_row             ROW_MASK = ROW_W'((17'd1 << LIM) - 17'd1);

    // Configuration registers
    logic             r_walk_mode;
    t_vertex          r_start_vertex;
    logic [CNT_W-1:0] r_vertex_count;

    // Matrix and pending store
    t_row             r_rows  [LIM];
    t_vertex          r_store [LIM];

    // Walk state
    t_state           r_state, n_state;
    logic [PW-1:0]    r_head, n_head;
    logic [PW-1:0]    r_tail, n_tail;
    t_row             r_visited, n_visited;
    t_vertex          r_cur, n_cur;
    logic             r_hold_valid, n_hold_valid;
    t_vertex          r_hold_v, n_hold_v;
    logic             r_out_valid, n_out_valid;
    t_vertex          r_out_v, n_out_v;
    logic             r_out_last, n_out_last;

    logic             w_wr_en;
    logic [PW-1:0]    w_wr_addr;
    t_vertex          w_wr_data;

    logic             w_cfg_wr;
    logic             w_in_fire;
    logic             w_start;
    logic             w_load;
    logic [CNT_W-1:0] w_n;
    logic             w_start_ok;
    logic             w_out_free;
    logic             w_can_emit;
    logic [PW-1:0]    w_rd_addr;
    t_vertex          w_rd_data;
    t_row             w_row_cur;
    t_lane_res [LANES-1:0] w_lanes;
    t_pick            w_pick;

    // APB port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walk_mode    <= MODE_BFS;
            r_start_vertex <= '0;
            r_vertex_count <= CNT_W'(VX_MAX);
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                REG_WALK_MODE:    r_walk_mode    <= pwdata[0];
                REG_START_VERTEX: r_start_vertex <= pwdata[VX_W-1:0];
                REG_VERTEX_COUNT: r_vertex_count <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[3:2])
            REG_WALK_MODE:    prdata = 32'(r_walk_mode);
            REG_START_VERTEX: prdata = 32'(r_start_vertex);
            REG_VERTEX_COUNT: prdata = 32'(r_vertex_count);
            default:          prdata = '0;
        endcase
    end

    // Effective vertex count, saturated to one and to the limit
    always_comb begin
        if (r_vertex_count == '0) begin
            w_n = CNT_W'(1);
        end else if (r_vertex_count > LIM_C) begin
            w_n = LIM_C;
        end else begin
            w_n = r_vertex_count;
        end
    end

    // Input handshake
    assign i_in_ch.ready = (r_state == ST_IDLE);
    assign w_in_fire     = i_in_ch.valid && i_in_ch.ready;
    assign w_start       = w_in_fire && (i_in_ch.opcode == OP_START);
    assign w_load        = w_in_fire && (i_in_ch.opcode == OP_LOAD);
    assign w_start_ok    = ({1'b0, r_start_vertex} < w_n);

    // Output register and the one-deep hold that waits for the last flag
    assign w_out_free = !r_out_valid || o_out_ch.ready;
    assign w_can_emit = !r_hold_valid || w_out_free;
    assign o_out_ch.valid          = r_out_valid;
    assign o_out_ch.visited_vertex = r_out_v;
    assign o_out_ch.last_vertex    = r_out_last;

    // Matrix rows: load in range, drop bits beyond the limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LIM; i++) begin
                r_rows[i] <= '0;
            end
        end else if (w_load && ({1'b0, i_in_ch.row_index} < LIM_C)) begin
            r_rows[i_in_ch.row_index[IW-1:0]] <= i_in_ch.row_bits & ROW_MASK;
        end
    end

    // Pending store: one write port, one read port
    assign w_rd_addr = (r_state == ST_DFS) ? (r_tail - TWO_P) : r_head;
    assign w_rd_data = r_store[w_rd_addr[IW-1:0]];

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_store[w_wr_addr[IW-1:0]] <= w_wr_data;
        end
    end

    // Search lanes over the current vertex's row
    assign w_row_cur = r_rows[r_cur[IW-1:0]];

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        amgt_lane #(
            .BASE (g * LANE_W)
        ) u_lane (
            .i_row     (w_row_cur[g*LANE_W +: LANE_W]),
            .i_visited (r_visited[g*LANE_W +: LANE_W]),
            .i_count   (w_n),
            .o_res     (w_lanes[g])
        );
    end

    amgt_merge u_merge (
        .i_lanes (w_lanes),
        .o_pick  (w_pick)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_start && w_start_ok) begin
                    n_state = (r_walk_mode == MODE_DFS) ? ST_DFS : ST_BFS_DEQ;
                end
            end
            ST_BFS_DEQ: begin
                if (r_head == r_tail) begin
                    n_state = ST_FINISH;
                end else if (w_can_emit) begin
                    n_state = ST_BFS_EXP;
                end
            end
            ST_BFS_EXP: begin
                if (!w_pick.found) begin
                    n_state = ST_BFS_DEQ;
                end
            end
            ST_DFS: begin
                if (!w_pick.found && (r_tail == ONE_P)) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath updates
    always_comb begin
        n_head       = r_head;
        n_tail       = r_tail;
        n_visited    = r_visited;
        n_cur        = r_cur;
        n_hold_valid = r_hold_valid;
        n_hold_v     = r_hold_v;
        n_out_valid  = r_out_valid && !o_out_ch.ready;
        n_out_v      = r_out_v;
        n_out_last   = r_out_last;
        w_wr_en      = 1'b0;
        w_wr_addr    = r_tail;
        w_wr_data    = w_pick.vertex;

        unique case (r_state)
            ST_IDLE: begin
                // Clear marks and pointers, seed with the start vertex
                if (w_start) begin
                    n_visited = '0;
                    n_head    = '0;
                    n_tail    = '0;
                    if (w_start_ok) begin
                        n_visited = ROW_W'(1) << r_start_vertex;
                        n_tail    = ONE_P;
                        n_cur     = r_start_vertex;
                        w_wr_en   = 1'b1;
                        w_wr_addr = '0;
                        w_wr_data = r_start_vertex;
                        if (r_walk_mode == MODE_DFS) begin
                            n_hold_valid = 1'b1;
                            n_hold_v     = r_start_vertex;
                        end
                    end
                end
            end
            ST_BFS_DEQ: begin
                // Dequeue and emit the head vertex
                if ((r_head != r_tail) && w_can_emit) begin
                    if (r_hold_valid) begin
                        n_out_valid = 1'b1;
                        n_out_v     = r_hold_v;
                        n_out_last  = 1'b0;
                    end
                    n_hold_valid = 1'b1;
                    n_hold_v     = w_rd_data;
                    n_cur        = w_rd_data;
                    n_head       = r_head + ONE_P;
                end
            end
            ST_BFS_EXP: begin
                // Enqueue the lowest unvisited neighbour
                if (w_pick.found) begin
                    w_wr_en   = 1'b1;
                    n_tail    = r_tail + ONE_P;
                    n_visited = r_visited | (ROW_W'(1) << w_pick.vertex);
                end
            end
            ST_DFS: begin
                if (w_pick.found) begin
                    // Visit and push the lowest unvisited neighbour
                    if (w_can_emit) begin
                        if (r_hold_valid) begin
                            n_out_valid = 1'b1;
                            n_out_v     = r_hold_v;
                            n_out_last  = 1'b0;
                        end
                        n_hold_valid = 1'b1;
                        n_hold_v     = w_pick.vertex;
                        w_wr_en      = 1'b1;
                        n_tail       = r_tail + ONE_P;
                        n_visited    = r_visited | (ROW_W'(1) << w_pick.vertex);
                        n_cur        = w_pick.vertex;
                    end
                end else begin
                    // Pop; the new top comes from the store
                    n_tail = r_tail - ONE_P;
                    if (r_tail != ONE_P) begin
                        n_cur = w_rd_data;
                    end
                end
            end
            ST_FINISH: begin
                // Release the held vertex with the last flag
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_v      = r_hold_v;
                    n_out_last   = 1'b1;
                    n_hold_valid = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_head       <= '0;
            r_tail       <= '0;
            r_visited    <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_visited    <= n_visited;
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_hold_v   <= n_hold_v;
        r_out_v    <= n_out_v;
        r_out_last <= n_out_last;
    end

    // Checks
    a_idle_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_hold_valid)
        else $error("held vertex left over while idle");

    a_tail_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail <= PW'(LIM))
        else $error("pending store overflow");

    a_bfs_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_BFS_DEQ) || (r_state == ST_BFS_EXP))
        |-> (($countones(r_visited) == int'(r_tail)) && (r_head <= r_tail)))
        else $error("queue and visited marks disagree");

    a_dfs_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DFS) |-> ($countones(r_visited) >= int'(r_tail)))
        else $error("stack deeper than visited set");

endmodule

### tb/tb_adjacency_matrix_graph_traversal_top.sv
`timescale 1ns / 1ps

module tb_adjacency_matrix_graph_traversal_top;
    import amgt_pkg::*;

    localparam int          SETTLE_CYCLES = 40;
    localparam int          LONG_HOLD     = 300;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int          PHASES        = 8;
    localparam int          PHASE_ITEMS   = 25;

    // Index with no register behind it
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef enum logic {STEP_ITEM, STEP_REG} t_step_kind;

    typedef struct {
        t_step_kind  kind;
        logic        op;
        t_vertex     row_idx;
        t_row        bits;
        logic [1:0]  reg_idx;
        logic [31:0] reg_val;
        int          typed_n;   // -1: ask the predictor
        t_vertex     typed_v;
    } t_plan_row;

    typedef struct {
        t_vertex vertex;
        logic    last;
    } t_visit;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    amgt_in_if  in_ch();
    amgt_out_if out_ch();

    // Shadow of the block: matrix and registers
    t_row        graph_rows [VX_MAX];
    logic        walk_mode_q;
    t_vertex     start_vertex_q;
    logic [4:0]  vertex_count_q;

    t_visit      expected_visits [$];
    int          mismatch_cnt = 0;
    int unsigned cycle_cnt = 0;
    bit          quiet_gaps;
    int          hold_reqs = 0;
    int          stall_left = 0;

    // Directed part: reset state, extremes and the corner cases
    t_plan_row directed_plan [31] = '{
        '{STEP_ITEM, OP_START, 4'd0,  16'h0000, REG_WALK_MODE,    32'd0,  1, 4'd0},
        '{STEP_ITEM, OP_LOAD,  4'd15, 16'hFFFF, REG_WALK_MODE,    32'd0, -1, 4'd0},
        '{STEP_ITEM, OP_LOAD,  4'd0,  16'h0007, REG_WALK_MODE,    32'd0, -1, 4'd0},
        '{STEP_ITEM, OP_LOAD,  4'd1,  16'h0009, REG_WALK_MODE,    32'd0, -1, 4'd0},
        '{STEP_ITEM, OP_LOAD,  4'd2,  16'h0009, REG_WALK_MODE,    32'd0, -1, 4'd0},
        '{STEP_ITEM, OP_LOAD,  4'd3,  16'h8006, REG_WALK_MODE,    32'd0, -1, 4'd0},
        '{STEP_ITEM, OP_LOAD,  4'd7,  16'h0001, REG_WALK_MODE,    32'd0, -1, 4'd0},
        '{STEP_ITEM, OP_START, 4'd15, 16'hFFFF, REG_WALK_MODE,    32'd0, -1, 4'd0},
        '{STEP_REG,  OP_LOAD,  4'd0,  16'h0000, REG_WALK_MODE,
          32'(MODE_DFS), -1, 4'd0},
        '{STEP_ITEM, OP_START, 4'd0,  16'h0000, REG_WALK_MODE,    32'd0, -1, 4'd0},
        '{STEP_REG,  OP_LOAD,  4'd0,  16'h0000, REG_START_VERTEX, 32'd15, -1, 4'd0},
        '{STEP_ITEM, OP_START, 4'd0,  16'h0000, REG_WALK_MODE,    32'd0, -1, 4'd0},
        '{STEP_REG,  OP_LOAD,  4'd0,  16'h0000, REG_VERTEX_COUNT, 32'd0, -1, 4'd0},
        '{STEP_ITEM, OP_START, 4'd0,  16'h0000, REG_WALK_MODE,    32'd0,  0, 4'd0},
        '{STEP_REG,  OP_LOAD,  4'd0,  16'h0000, REG_START_VERTEX, 32'd0, -1, 4'd0},
        '{STEP_ITEM, OP_START, 4'd0,  16'h0000, REG_WALK_MODE,    32'd0,  1, 4'd0},
        '{STEP_REG,  OP_LOAD,  4'd0,  16'h0000, REG_VERTEX_COUNT, 32'd31, -1, 4'd0},
        '{STEP_ITEM, OP_START, 4'd0,  16'h0000, REG_WALK_MODE,    32'd0, -1, 4'd0},
        '{STEP_REG,  OP_LOAD,  4'd0,  16'h0000, REG_VERTEX_COUNT, 32'd4, -1, 4'd0},
        '{STEP_ITEM, OP_START, 4'd0,  16'h0000, REG_WALK_MODE,    32'd0, -1, 4'd0},
        '{STEP_REG,  OP_LOAD,  4'd0,  16'h0000, REG_WALK_MODE,
          32'(MODE_BFS), -1, 4'd0},
        '{STEP_REG,  OP_LOAD,  4'd0,  16'h0000, REG_UNUSED,       32'd1, -1, 4'd0},
        '{STEP_ITEM, OP_START, 4'd0,  16'h0000, REG_WALK_MODE,    32'd0, -1, 4'd0},
        '{STEP_REG,  OP_LOAD,  4'd0,  16'h0000, REG_START_VERTEX, 32'd7, -1, 4'd0},
        '{STEP_ITEM, OP_START, 4'd0,  16'h0000, REG_WALK_MODE,    32'd0,  0, 4'd0},
        '{STEP_REG,  OP_LOAD,  4'd0,  16'h0000, REG_VERTEX_COUNT, 32'd16, -1, 4'd0},
        '{STEP_ITEM, OP_START, 4'd0,  16'h0000, REG_WALK_MODE,    32'd0, -1, 4'd0},
        '{STEP_ITEM, OP_LOAD,  4'd15, 16'h0000, REG_WALK_MODE,    32'd0, -1, 4'd0},
        '{STEP_ITEM, OP_START, 4'd0,  16'h0000, REG_WALK_MODE,    32'd0, -1, 4'd0},
        '{STEP_ITEM, OP_LOAD,  4'd0,  16'h0000, REG_WALK_MODE,    32'd0, -1, 4'd0},
        '{STEP_ITEM, OP_START, 4'd0,  16'h0000, REG_WALK_MODE,    32'd0, -1, 4'd0}
    };

    adjacency_matrix_graph_traversal_top u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Abort the run once the cycle limit is reached
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("adjacency_matrix_graph_traversal_top: mismatch");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        mismatch_cnt++;
    endtask

    // Mostly short gaps, a few long ones; none in quiet phases
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_gaps || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic t_row pick_row_bits();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2, 3: return t_row'($urandom & $urandom);
            4: return t_row'($urandom);
            default: return t_row'($urandom | $urandom);
        endcase
    endfunction

    // Work out the visit order of one traversal and queue it
    function automatic void predict_walk();
        t_vertex order [$];
        t_vertex pending [$];
        t_row    seen;
        t_row    nbrs;
        t_row    mask;
        t_vertex v;
        int      n;
        int      j;
        n = vertex_count_q;
        if (n == 0)
            n = 1;
        if (n > VX_MAX)
            n = VX_MAX;
        if (start_vertex_q >= n)
            return;
        mask = (n >= VX_MAX) ? '1 : t_row'((1 << n) - 1);
        seen = '0;
        if (walk_mode_q == MODE_BFS) begin
            // Mark on entry, neighbours in ascending order
            pending.push_back(start_vertex_q);
            seen[start_vertex_q] = 1'b1;
            while (pending.size() > 0) begin
                v = pending.pop_front();
                order.push_back(v);
                nbrs = graph_rows[v] & mask & ~seen;
                for (j = 0; j < VX_MAX; j++) begin
                    if (nbrs[j]) begin
                        pending.push_back(t_vertex'(j));
                        seen[j] = 1'b1;
                    end
                end
            end
        end else begin
            // Path stack: descend to the lowest unseen neighbour, else pop
            order.push_back(start_vertex_q);
            seen[start_vertex_q] = 1'b1;
            pending.push_back(start_vertex_q);
            while (pending.size() > 0) begin
                v = pending[$];
                nbrs = graph_rows[v] & mask & ~seen;
                if (nbrs == '0) begin
                    void'(pending.pop_back());
                end else begin
                    for (j = 0; j < VX_MAX; j++)
                        if (nbrs[j])
                            break;
                    order.push_back(t_vertex'(j));
                    seen[j] = 1'b1;
                    pending.push_back(t_vertex'(j));
                end
            end
        end
        foreach (order[k])
            expected_visits.push_back('{vertex: order[k], last: (k == order.size() - 1)});
    endfunction

    // Offer one beat, apply it to the shadow once it is taken
    task automatic send_item(input logic op, input t_vertex idx, input t_row bits,
                             input int typed_n, input t_vertex typed_v);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.opcode    <= op;
        in_ch.row_index <= idx;
        in_ch.row_bits  <= bits;
        do @(negedge i_clk); while (!in_ch.ready);
        @(posedge i_clk);
        if (op == OP_LOAD)
            graph_rows[idx] = bits;
        else if (typed_n < 0)
            predict_walk();
        else if (typed_n == 1)
            expected_visits.push_back('{vertex: typed_v, last: 1'b1});
    endtask

    // Drop valid, drain every result, then let the block go idle
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (expected_visits.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(negedge i_clk); while (!pready);
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_WALK_MODE:    walk_mode_q    = value[0];
            REG_START_VERTEX: start_vertex_q = value[3:0];
            REG_VERTEX_COUNT: vertex_count_q = value[4:0];
            default: ;
        endcase
    endtask

    // Result side: random stalls, one long hold on request
    initial begin
        int holds_done;
        holds_done = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_reqs != holds_done) begin
                stall_left = LONG_HOLD;
                holds_done = hold_reqs;
            end
            if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
            @(negedge i_clk);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                if (expected_visits.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat vertex %0d last %0b",
                                              out_ch.visited_vertex, out_ch.last_vertex));
                end else begin
                    t_visit exp_v;
                    exp_v = expected_visits.pop_front();
                    if (out_ch.visited_vertex !== exp_v.vertex)
                        report_mismatch($sformatf("visited_vertex %0d, expected %0d",
                                                  out_ch.visited_vertex, exp_v.vertex));
                    if (out_ch.last_vertex !== exp_v.last)
                        report_mismatch($sformatf("last_vertex %0b, expected %0b on vertex %0d",
                                                  out_ch.last_vertex, exp_v.last, exp_v.vertex));
                end
            end
        end
    end

    initial begin
        int phase;
        int k;
        int cnt;
        int eff;
        t_vertex idx;

        // Hold reset with every input at a known value
        i_rst_n         <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.opcode    <= OP_LOAD;
        in_ch.row_index <= '0;
        in_ch.row_bits  <= '0;
        foreach (graph_rows[r])
            graph_rows[r] = '0;
        walk_mode_q    = MODE_BFS;
        start_vertex_q = '0;
        vertex_count_q = 5'd16;
        quiet_gaps     = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        foreach (directed_plan[i]) begin
            if (directed_plan[i].kind == STEP_REG) begin
                settle();
                write_reg(directed_plan[i].reg_idx, directed_plan[i].reg_val);
            end else begin
                send_item(directed_plan[i].op, directed_plan[i].row_idx,
                          directed_plan[i].bits, directed_plan[i].typed_n,
                          directed_plan[i].typed_v);
            end
        end

        // Random phases, each under a fresh register setting
        for (phase = 0; phase < PHASES; phase++) begin
            settle();
            quiet_gaps = (phase == 3 || phase == 6);
            write_reg(REG_WALK_MODE, 32'($urandom_range(0, 1)));
            case ($urandom_range(0, 9))
                0: cnt = $urandom_range(0, 1) ? 0 : $urandom_range(17, 31);
                1, 2: cnt = VX_MAX;
                default: cnt = $urandom_range(1, VX_MAX);
            endcase
            eff = (cnt == 0) ? 1 : (cnt > VX_MAX) ? VX_MAX : cnt;
            write_reg(REG_VERTEX_COUNT, 32'(cnt));
            if ($urandom_range(0, 9) == 0)
                write_reg(REG_START_VERTEX, 32'($urandom_range(0, 15)));
            else
                write_reg(REG_START_VERTEX, 32'($urandom_range(0, eff - 1)));
            // Let the result side hold off while loads and starts pile up
            if (phase == 1 || phase == 5)
                hold_reqs++;
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(0, 9) < 3) begin
                    send_item(OP_START, t_vertex'($urandom), t_row'($urandom), -1, '0);
                end else begin
                    if ($urandom_range(0, 3) == 0)
                        idx = t_vertex'($urandom_range(0, 15));
                    else
                        idx = t_vertex'($urandom_range(0, eff - 1));
                    send_item(OP_LOAD, idx, pick_row_bits(), -1, '0);
                end
            end
        end

        settle();
        if (expected_visits.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_visits.size()));
        if (mismatch_cnt == 0)
            $display("adjacency_matrix_graph_traversal_top: match");
        else
            $display("adjacency_matrix_graph_traversal_top: mismatch");
        $finish;
    end

endmodule

### adjacency_matrix_graph_traversal_top.f
rtl/core/amgt_pkg.sv
rtl/core/amgt_if.sv
rtl/core/amgt_lane.sv
rtl/core/amgt_merge.sv
rtl/core/adjacency_matrix_graph_traversal_top.sv
tb/tb_adjacency_matrix_graph_traversal_top.sv
